// ===== rtl/core/gnd_pkg.sv =====
package gnd_pkg;

    localparam int COORDS_W      = 64;
    localparam int SLOT_W        = 10;
    localparam int COUNT_W       = 20;
    localparam int DENSITY_W     = 32;
    localparam int ENTRY_COUNT_W = 11;
    localparam int DIMS_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;

    localparam int DEF_MAX_CELLS  = 1024;
    localparam int DEF_MAX_DIMS   = 8;
    localparam int DEF_COORD_BITS = 8;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 2'd1;

    typedef struct packed {
        logic clear;
        logic valid;
    } acc_ctl_t;

endpackage

// ===== rtl/core/gnd_table.sv =====
module gnd_table #(
    parameter int MAX_CELLS = gnd_pkg::DEF_MAX_CELLS,
    parameter int ADDR_W    = 10
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [gnd_pkg::COORDS_W-1:0]  wr_coords,
    input  logic [gnd_pkg::COUNT_W-1:0]   wr_count,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [gnd_pkg::COORDS_W-1:0]  rd_coords,
    output logic [gnd_pkg::COUNT_W-1:0]   rd_count
);
    import gnd_pkg::*;

    logic [COORDS_W+COUNT_W-1:0] mem [MAX_CELLS];
    logic [COORDS_W+COUNT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_coords, wr_count};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_coords = rd_data_reg[COORDS_W+COUNT_W-1:COUNT_W];
    assign rd_count  = rd_data_reg[COUNT_W-1:0];

endmodule

// ===== rtl/core/gnd_lane.sv =====
module gnd_lane #(
    parameter int COORD_BITS = gnd_pkg::DEF_COORD_BITS,
    parameter int LANE       = 0
) (
    input  logic                          enable,
    input  logic [gnd_pkg::COORDS_W-1:0]  query_coords,
    input  logic [gnd_pkg::COORDS_W-1:0]  entry_coords,
    output logic                          near
);
    import gnd_pkg::*;

    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS:0]   xe;
    logic [COORD_BITS:0]   ye;

    always_comb begin
        int pos;
        x = '0;
        y = '0;
        for (int b = 0; b < COORD_BITS; b++) begin
            pos = LANE * COORD_BITS + b;
            if (pos < COORDS_W) begin
                x[b] = query_coords[pos[5:0]];
                y[b] = entry_coords[pos[5:0]];
            end
        end
    end

    assign xe = {1'b0, x};
    assign ye = {1'b0, y};

    assign near = !enable || (xe == ye) || (xe == ye + 1'b1) || (ye == xe + 1'b1);

endmodule

// ===== rtl/core/gnd_merge.sv =====
module gnd_merge #(
    parameter int MAX_DIMS = gnd_pkg::DEF_MAX_DIMS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gnd_pkg::acc_ctl_t              ctl,
    input  logic [MAX_DIMS-1:0]            near,
    input  logic [gnd_pkg::COUNT_W-1:0]    count,
    output logic                           busy,
    output logic [gnd_pkg::DENSITY_W-1:0]  density
);
    import gnd_pkg::*;

    logic                 v_reg;
    logic                 hit_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [DENSITY_W-1:0] acc_reg;
    logic [DENSITY_W-1:0] acc_next;
    logic [DENSITY_W:0]   sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= &near;
        cnt_reg <= count;
    end

    assign sum = {1'b0, acc_reg} + (DENSITY_W+1)'(cnt_reg);

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (v_reg && hit_reg) begin
            acc_next = sum[DENSITY_W] ? '1 : sum[DENSITY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign busy    = v_reg;
    assign density = acc_reg;

endmodule

// ===== rtl/core/grid_neighbor_density.sv =====
// Neighborhood density over a table of grid cells. A write item (op 0) stores
// coordinates and a point count at a slot; slots at or beyond MAX_CELLS are
// dropped. A query item (op 1) scans slots 0 to min(entry_count, MAX_CELLS)-1
// through the single read port of the cell table, one cell per cycle, with one
// comparator lane per dimension, and sums the counts of cells within distance
// 1 in every dimension in use, saturating at 2^32-1. A query occupies the block
// until its scan is merged and the output register is free; the result then
// waits there while the next item is taken. Every scanned slot must have been
// written since reset. Configuration writes take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
module grid_neighbor_density #(
    parameter int MAX_CELLS  = gnd_pkg::DEF_MAX_CELLS,
    parameter int MAX_DIMS   = gnd_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS = gnd_pkg::DEF_COORD_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gnd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gnd_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [gnd_pkg::SLOT_W-1:0]       s_slot,
    input  logic [gnd_pkg::COORDS_W-1:0]     s_coords,
    input  logic [gnd_pkg::COUNT_W-1:0]      s_point_count,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gnd_pkg::DENSITY_W-1:0]    m_density
);
    import gnd_pkg::*;

    localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic [DIMS_W-1:0]        dims_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [COORDS_W-1:0]      q_coords_reg;
    logic                     rd_v_reg;
    logic                     m_valid_reg;
    logic [DENSITY_W-1:0]     m_density_reg;

    logic                     s_fire;
    logic                     wr_en;
    logic [31:0]              slot32;
    logic [31:0]              ec32;
    logic [31:0]              n32;
    logic                     issue;
    logic                     done;
    logic [COORDS_W-1:0]      rd_coords;
    logic [COUNT_W-1:0]       rd_count;
    logic [MAX_DIMS-1:0]      near;
    logic                     merge_busy;
    logic [DENSITY_W-1:0]     density;
    acc_ctl_t                 acc_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            dims_reg        <= DIMS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[ENTRY_COUNT_W-1:0];
                REG_DIMS_IN_USE: dims_reg        <= cfg_data[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign slot32 = 32'(s_slot);
    assign wr_en  = s_fire && (s_op == OP_WRITE) && (slot32 < 32'(MAX_CELLS));

    assign ec32   = 32'(entry_count_reg);
    assign n32    = (ec32 > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : ec32;
    assign n_next = n32[CNT_W-1:0];

    assign issue = (state_reg == ST_SCAN);
    assign done  = !rd_v_reg && !merge_busy && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_op == OP_QUERY)) begin
                    idx_next   = '0;
                    state_next = (n_next == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_next == n_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (s_fire && (s_op == OP_QUERY)) begin
            n_reg        <= n_next;
            q_coords_reg <= s_coords;
        end
    end

    gnd_table #(
        .MAX_CELLS (MAX_CELLS),
        .ADDR_W    (ADDR_W)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (slot32[ADDR_W-1:0]),
        .wr_coords (s_coords),
        .wr_count  (s_point_count),
        .rd_en     (issue),
        .rd_addr   (idx_reg[ADDR_W-1:0]),
        .rd_coords (rd_coords),
        .rd_count  (rd_count)
    );

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
        gnd_lane #(
            .COORD_BITS (COORD_BITS),
            .LANE       (d)
        ) u_lane (
            .enable       (32'(dims_reg) > 32'(d)),
            .query_coords (q_coords_reg),
            .entry_coords (rd_coords),
            .near         (near[d])
        );
    end

    assign acc_ctl.clear = s_fire && (s_op == OP_QUERY);
    assign acc_ctl.valid = rd_v_reg;

    gnd_merge #(
        .MAX_DIMS (MAX_DIMS)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .near    (near),
        .count   (rd_count),
        .busy    (merge_busy),
        .density (density)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DRAIN) && done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DRAIN) && done) begin
            m_density_reg <= density;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_density = m_density_reg;

endmodule
